// ===== rtl/hlru_pkg.sv =====
package hlru_pkg;

   // MurmurHash64A constants for an 8-byte key.
   localparam logic [63:0] HASH_MUL  = 64'hc6a4a7935bd1e995;
   localparam logic [63:0] HASH_SEED = 64'h00000000cafebabe;
   localparam logic [63:0] HASH_H0   = HASH_SEED ^ (HASH_MUL << 3);
   localparam int          HASH_SHIFT  = 47;
   localparam int          HASH_ROUNDS = 4;

   localparam int MIN_PRECISION = 8;
   localparam int MAX_PRECISION = 15;

   // Depth of the queue between the hash front end and the update back end.
   localparam int QUEUE_DEPTH = 8;

   // Widest rank memory address over the whole parameter range.
   localparam int ADDR_MAX_W = 16;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      BK_CLEAR  = 2'd0,
      BK_IDLE   = 2'd1,
      BK_LOOKUP = 2'd2
   } back_state_type;

   typedef struct packed {
      action_type              action;
      logic [ADDR_MAX_W-1:0]   addr;
      logic [13:0]             index_used;
      logic [5:0]              item_rank;
      logic [5:0]              wr_rank;
      logic                    index_error;
   } hlru_entry_type;

   typedef struct packed {
      logic [13:0] index_used;
      logic [5:0]  item_rank;
      logic [5:0]  stored_rank;
      logic        changed;
      logic        index_error;
   } hlru_result_type;

endpackage

// ===== rtl/hlru_ram.sv =====
module hlru_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/hlru_fifo.sv =====
module hlru_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  hlru_pkg::hlru_entry_type push_entry,
   input  logic                    pop,
   output hlru_pkg::hlru_entry_type pop_entry,
   output logic                    empty
);
   import hlru_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   hlru_entry_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
      if (push) begin
         tail_in = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_entry;
      end
   end

   assign pop_entry = slot_ff[head_ff];
   assign empty     = (count_ff == '0);

endmodule

// ===== rtl/hlru_front.sv =====
module hlru_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    hold,
   input  logic                    push,
   output logic                    full,
   input  logic [1:0]              action,
   input  logic signed [63:0]      item_value,
   input  logic [13:0]             reg_index,
   input  logic [5:0]              reg_rank,
   input  logic [3:0]              precision,
   input  logic                    queue_pop,
   output logic                    entry_valid,
   output hlru_pkg::hlru_entry_type entry
);
   import hlru_pkg::*;

   typedef struct packed {
      action_type  action;
      logic [13:0] reg_index;
      logic [5:0]  reg_rank;
   } meta_type;

   localparam int STAGES = 2 * HASH_ROUNDS;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   logic                accept;
   logic [CNT_W-1:0]    credit_ff, credit_in;

   logic [STAGES-1:0]   valid_ff;
   meta_type            meta_ff   [STAGES];
   logic [63:0]         pp_lo_ff  [HASH_ROUNDS];
   logic [31:0]         pp_mid_ff [HASH_ROUNDS];
   logic [63:0]         val_ff    [HASH_ROUNDS];

   logic [63:0]         mul_a [HASH_ROUNDS];
   logic [63:0]         prod  [HASH_ROUNDS];
   logic [63:0]         post  [HASH_ROUNDS];

   hlru_entry_type      entry_ff, entry_in;
   logic                entry_valid_ff;

   // Items in flight through the hash pipeline or waiting in the queue.
   assign full      = hold || (credit_ff == CNT_W'(QUEUE_DEPTH));
   assign accept    = push && !full;
   assign credit_in = credit_ff + CNT_W'(accept) - CNT_W'(queue_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff      <= '0;
         valid_ff       <= '0;
         entry_valid_ff <= 1'b0;
      end else begin
         credit_ff      <= credit_in;
         valid_ff       <= {valid_ff[STAGES-2:0], accept};
         entry_valid_ff <= valid_ff[STAGES-1];
      end
   end

   // Each 64-bit multiply by the constant keeps only the low 64 bits of the
   // product: one 32x32 full product and two cross terms of which only the
   // low 32 bits count. The partial products are summed one stage later.
   always_comb begin
      mul_a[0] = $unsigned(item_value);
      for (int r = 1; r < HASH_ROUNDS; r++) begin
         mul_a[r] = val_ff[r-1];
      end
      for (int r = 0; r < HASH_ROUNDS; r++) begin
         prod[r] = pp_lo_ff[r] + {pp_mid_ff[r], 32'b0};
         if (r == 1) begin
            post[r] = prod[r] ^ HASH_H0;
         end else begin
            post[r] = prod[r] ^ (prod[r] >> HASH_SHIFT);
         end
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= '{action: action_type'(action), reg_index: reg_index,
                      reg_rank: reg_rank};
      for (int s = 1; s < STAGES; s++) begin
         meta_ff[s] <= meta_ff[s-1];
      end
      for (int r = 0; r < HASH_ROUNDS; r++) begin
         pp_lo_ff[r]  <= 64'(mul_a[r][31:0]) * 64'(HASH_MUL[31:0]);
         pp_mid_ff[r] <= 32'(mul_a[r][31:0] * HASH_MUL[63:32])
                       + 32'(mul_a[r][63:32] * HASH_MUL[31:0]);
         val_ff[r]    <= post[r];
      end
   end

   // Classification of the finished hash or of the register access.
   always_comb begin
      logic [63:0] hash;
      logic [6:0]  tz;
      logic [6:0]  rank;
      logic [6:0]  limit;
      logic [4:0]  shift;
      logic [15:0] idx;
      logic [15:0] nregs;
      meta_type    m;

      hash  = val_ff[HASH_ROUNDS-1];
      m     = meta_ff[STAGES-1];
      shift = 5'd16 - 5'(precision);
      idx   = hash[63:48] >> shift;
      nregs = 16'(1) << precision;
      limit = 7'd64 - 7'(precision);

      tz = 7'd64;
      for (int i = 63; i >= 0; i--) begin
         if (hash[i]) begin
            tz = 7'(i);
         end
      end
      rank = tz + 7'd1;
      if (rank > limit) begin
         rank = limit;
      end
      if (hash == '0) begin
         rank = '0;
      end

      entry_in.action      = m.action;
      entry_in.wr_rank     = m.reg_rank;
      if (m.action == ACT_ADD) begin
         entry_in.addr        = idx;
         entry_in.index_used  = idx[13:0];
         entry_in.item_rank   = rank[5:0];
         entry_in.index_error = 1'b0;
      end else begin
         entry_in.addr        = {2'b00, m.reg_index};
         entry_in.index_used  = m.reg_index;
         entry_in.item_rank   = '0;
         entry_in.index_error = (m.action != ACT_NOP) && ({2'b00, m.reg_index} >= nregs);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_valid = entry_valid_ff;
   assign entry       = entry_ff;

endmodule

// ===== rtl/hlru_back.sv =====
module hlru_back #(
   parameter int MAX_REGISTERS = 16384
) (
   input  logic                     clock,
   input  logic                     reset,
   output logic                     clearing,
   input  logic                     queue_empty,
   input  hlru_pkg::hlru_entry_type queue_entry,
   output logic                     queue_pop,
   output logic                     result_valid,
   output hlru_pkg::hlru_result_type result,
   input  logic                     result_pop
);
   import hlru_pkg::*;

   localparam int ADDR_W = $clog2(MAX_REGISTERS);

   back_state_type   state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   hlru_entry_type   cur_ff, cur_in;
   hlru_result_type  res_ff, res_in;
   logic             res_valid_ff, res_valid_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [5:0]        ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [5:0]        ram_rdata;

   hlru_ram #(
      .WIDTH (6),
      .DEPTH (MAX_REGISTERS)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_addr_ff  <= '0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      res_ff <= res_in;
   end

   // One read-modify-write per entry: the read is issued when the entry
   // leaves the queue; the update is made and the result registered in the
   // next cycle. The write lands before the next entry's read is issued.
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cur_in       = cur_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !result_pop;
      queue_pop    = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = cur_ff.addr[ADDR_W-1:0];
      ram_wdata    = '0;
      ram_raddr    = queue_entry.addr[ADDR_W-1:0];

      unique case (state_ff)
         BK_CLEAR: begin
            ram_we      = 1'b1;
            ram_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(MAX_REGISTERS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!queue_empty && (!res_valid_ff || result_pop)) begin
               queue_pop = 1'b1;
               cur_in    = queue_entry;
               state_in  = BK_LOOKUP;
            end
         end
         BK_LOOKUP: begin
            res_in.index_used  = cur_ff.index_used;
            res_in.item_rank   = cur_ff.item_rank;
            res_in.stored_rank = '0;
            res_in.changed     = 1'b0;
            res_in.index_error = cur_ff.index_error;
            unique case (cur_ff.action)
               ACT_ADD: begin
                  if (ram_rdata < cur_ff.item_rank) begin
                     ram_we             = 1'b1;
                     ram_wdata          = cur_ff.item_rank;
                     res_in.stored_rank = cur_ff.item_rank;
                     res_in.changed     = 1'b1;
                  end else begin
                     res_in.stored_rank = ram_rdata;
                  end
               end
               ACT_WRITE: begin
                  if (!cur_ff.index_error) begin
                     ram_we             = 1'b1;
                     ram_wdata          = cur_ff.wr_rank;
                     res_in.stored_rank = cur_ff.wr_rank;
                     res_in.changed     = 1'b1;
                  end
               end
               ACT_READ: begin
                  if (!cur_ff.index_error) begin
                     res_in.stored_rank = ram_rdata;
                  end
               end
               ACT_NOP: begin
               end
            endcase
            res_valid_in = 1'b1;
            state_in     = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign clearing     = (state_ff == BK_CLEAR);
   assign result_valid = res_valid_ff;
   assign result       = res_ff;

endmodule

// ===== rtl/hyperloglog_register_update.sv =====
// HyperLogLog register bank with MurmurHash64A hashing. An add transaction
// hashes its 64-bit item, picks a register from the top precision bits of
// the hash and raises it to the item's rank; write and read transactions
// load or return one register directly. After reset the rank memory is
// swept to zero, one entry per cycle, and full stays high until the sweep
// is done (the precision register can be written during the sweep). An
// item passes through the hash pipeline, sits in an eight-entry queue, and
// then goes through the update unit, whose read-modify-write of the rank
// memory through a registered read, with no forwarding from one update to
// the next, keeps it from taking a new entry before the last one is done.
// At most eight items are held between the input and the update unit; a
// finished result waits in an output register, and the update unit takes
// its next entry no earlier than the cycle in which that result is popped.
module hyperloglog_register_update #(
   parameter int MAX_REGISTERS = 16384
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_action,
   input  logic signed [63:0] req_item_value,
   input  logic [13:0]        req_reg_index,
   input  logic [5:0]         req_reg_rank,

   output logic               empty,
   input  logic               pop,
   output logic [13:0]        rsp_index_used,
   output logic [5:0]         rsp_item_rank,
   output logic [5:0]         rsp_stored_rank,
   output logic               rsp_changed,
   output logic               rsp_index_error,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_data
);
   import hlru_pkg::*;

   localparam int PMAX_RAW = $clog2(MAX_REGISTERS + 1) - 1;
   localparam int PMAX     = (PMAX_RAW > MAX_PRECISION) ? MAX_PRECISION : PMAX_RAW;

   logic [3:0]      precision_ff, precision_in;
   logic [3:0]      precision_eff;
   logic            clearing;
   logic            entry_valid;
   hlru_entry_type  front_entry;
   hlru_entry_type  queue_entry;
   logic            queue_empty;
   logic            queue_pop;
   logic            result_valid;
   hlru_result_type result;

   assign csr_ready    = 1'b1;
   assign precision_in = (csr_valid && csr_ready) ? csr_data : precision_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         precision_ff <= 4'd14;
      end else begin
         precision_ff <= precision_in;
      end
   end

   always_comb begin
      precision_eff = precision_ff;
      if (precision_ff < 4'(MIN_PRECISION)) begin
         precision_eff = 4'(MIN_PRECISION);
      end else if (precision_ff > 4'(PMAX)) begin
         precision_eff = 4'(PMAX);
      end
   end

   hlru_front u_front (
      .clock       (clock),
      .reset       (reset),
      .hold        (clearing),
      .push        (push),
      .full        (full),
      .action      (req_action),
      .item_value  (req_item_value),
      .reg_index   (req_reg_index),
      .reg_rank    (req_reg_rank),
      .precision   (precision_eff),
      .queue_pop   (queue_pop),
      .entry_valid (entry_valid),
      .entry       (front_entry)
   );

   hlru_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (entry_valid),
      .push_entry (front_entry),
      .pop        (queue_pop),
      .pop_entry  (queue_entry),
      .empty      (queue_empty)
   );

   hlru_back #(
      .MAX_REGISTERS (MAX_REGISTERS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .clearing     (clearing),
      .queue_empty  (queue_empty),
      .queue_entry  (queue_entry),
      .queue_pop    (queue_pop),
      .result_valid (result_valid),
      .result       (result),
      .result_pop   (pop && !empty)
   );

   assign empty           = !result_valid;
   assign rsp_index_used  = result.index_used;
   assign rsp_item_rank   = result.item_rank;
   assign rsp_stored_rank = result.stored_rank;
   assign rsp_changed     = result.changed;
   assign rsp_index_error = result.index_error;

endmodule
